[hw/rtl/montgomery_mod_arith_64_assert.svh]
// Assertion macros shared by the Montgomery unit's checker.
// No dependencies.
`ifndef MONTGOMERY_MOD_ARITH_64_ASSERT_SVH
`define MONTGOMERY_MOD_ARITH_64_ASSERT_SVH

// property that holds on every clock edge outside reset
`define MMA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// property checked including the reset cycles
`define MMA_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[hw/rtl/mma_pkg.sv]
// Shared types and constants for the Montgomery modular arithmetic unit.
// No dependencies.
package mma_pkg;
   localparam int RES_BITS = 63;
   localparam int MODE_BITS = 3;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_ADD = 3'd0,
      MODE_SUB = 3'd1,
      MODE_MUL = 3'd2,
      MODE_TO_MONT = 3'd3,
      MODE_FROM_MONT = 3'd4
   } mode_type;

   localparam logic [1:0] CSR_MODULUS = 2'd0;
   localparam logic [1:0] CSR_INVERSE = 2'd1;
   localparam logic [1:0] CSR_R_SQUARED = 2'd2;
endpackage

[hw/rtl/montgomery_mod_arith_64.sv]
// Montgomery modular arithmetic unit, top level.
// Eight register stages from input beat to result beat: three 2-stage
// multipliers, then a subtract and a correction stage. Throughput: one beat per cycle when not stalled.
// A stall freezes the whole pipeline; the output register holds its beat.
// Reset (synchronous, active high) clears valid bits and sets modulus=1,
// inverse=1, r_squared=0.
module montgomery_mod_arith_64 #(
   parameter int WORD_BITS = 64
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [135:0]   req_tdata,  // mode[2:0], operand_a[66:3], operand_b[129:67]
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [63:0]    rsp_tdata,  // result[62:0]
   input  logic           csr_we,
   input  logic [1:0]     csr_index,
   input  logic [63:0]    csr_wdata
);
   import mma_pkg::*;
   localparam int W = WORD_BITS;
   localparam int D = 7;
   localparam int SB = MODE_BITS + 2*W;

   logic [RES_BITS-1:0] modulus_ff, r2_ff;
   logic [63:0] inv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= RES_BITS'(1);
         inv_ff <= 64'd1;
         r2_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODULUS: modulus_ff <= csr_wdata[RES_BITS-1:0];
            CSR_INVERSE: inv_ff <= csr_wdata;
            CSR_R_SQUARED: r2_ff <= csr_wdata[RES_BITS-1:0];
            default: ;
         endcase
      end
   end

   logic [W-1:0] m_w, inv_w, r2_w;
   assign m_w = W'({1'b0, modulus_ff});
   assign inv_w = inv_ff[W-1:0];
   assign r2_w = W'({1'b0, r2_ff});

   // global advance: pipeline moves when the output is free or taken
   logic adv;
   logic [D-1:0] vld_ff;
   logic out_vld_ff;
   logic [RES_BITS-1:0] out_res_ff;
   assign adv = !out_vld_ff || rsp_tready;
   assign req_tready = adv;

   logic [MODE_BITS-1:0] in_mode;
   logic [W-1:0] in_a, in_b, mul_b;
   assign in_mode = req_tdata[2:0];
   assign in_a = req_tdata[3 +: W];
   assign in_b = W'({1'b0, req_tdata[67 +: RES_BITS]});
   always_comb begin
      case (in_mode)
         MODE_ADD, MODE_SUB, MODE_MUL: mul_b = in_b;
         MODE_TO_MONT: mul_b = r2_w;
         default: mul_b = W'(1);
      endcase
   end

   // stage A: x = a*b (or a*r2, a*1)
   logic [2*W-1:0] x_prod;
   logic [SB-1:0] side_a;
   mma_mult #(.W(W), .SIDE(SB)) u_mul_x (
      .clock(clock), .enable(adv), .in_a(in_a), .in_b(mul_b),
      .in_side({in_b, in_a, in_mode}), .out_prod(x_prod), .out_side(side_a));

   // stage B: t = lo(x)*inv
   logic [2*W-1:0] t_prod;
   logic [SB+W-1:0] side_b;
   mma_mult #(.W(W), .SIDE(SB+W)) u_mul_t (
      .clock(clock), .enable(adv), .in_a(x_prod[W-1:0]), .in_b(inv_w),
      .in_side({x_prod[2*W-1:W], side_a}), .out_prod(t_prod), .out_side(side_b));

   // stage C: t*m
   logic [2*W-1:0] tm_prod;
   logic [SB+W-1:0] side_c;
   mma_mult #(.W(W), .SIDE(SB+W)) u_mul_m (
      .clock(clock), .enable(adv), .in_a(t_prod[W-1:0]), .in_b(m_w),
      .in_side(side_b), .out_prod(tm_prod), .out_side(side_c));

   logic [MODE_BITS-1:0] c_mode;
   logic [W-1:0] c_a, c_b, c_hi, y_in, y_ff;
   logic [MODE_BITS-1:0] y_mode_ff;
   assign c_mode = side_c[MODE_BITS-1:0];
   assign c_a = side_c[MODE_BITS +: W];
   assign c_b = side_c[MODE_BITS+W +: W];
   assign c_hi = side_c[SB +: W];
   always_comb begin
      case (c_mode)
         MODE_ADD: y_in = c_a + c_b - m_w;
         MODE_SUB: y_in = c_a - c_b;
         MODE_MUL, MODE_TO_MONT, MODE_FROM_MONT: y_in = c_hi - tm_prod[2*W-1:W];
         default: y_in = '0;
      endcase
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         y_ff <= y_in;
         y_mode_ff <= c_mode;
      end
   end

   // correction stage into the output register
   logic [W-1:0] fix;
   assign fix = y_ff[W-1] ? y_ff + m_w : y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= {vld_ff[D-2:0], req_tvalid};
         out_vld_ff <= vld_ff[D-1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         out_res_ff <= (y_mode_ff > MODE_FROM_MONT) ? '0 : RES_BITS'({1'b0, fix});
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = {1'b0, out_res_ff};
endmodule

[hw/rtl/mma_mult.sv]
// Pipelined W x W multiplier: two register stages (partial products, sum).
// Carries a side payload alongside. Depends on nothing else.
module mma_mult #(
   parameter int W = 64,
   parameter int SIDE = 8
) (
   input  logic              clock,
   input  logic              enable,
   input  logic [W-1:0]      in_a,
   input  logic [W-1:0]      in_b,
   input  logic [SIDE-1:0]   in_side,
   output logic [2*W-1:0]    out_prod,
   output logic [SIDE-1:0]   out_side
);
   localparam int H = W / 2;
   localparam int L = W - H;

   logic [2*L-1:0] p00_ff;
   logic [L+H-1:0] p01_ff, p10_ff;
   logic [2*H-1:0] p11_ff;
   logic [SIDE-1:0] side_ff;
   logic [2*W-1:0] prod_ff;
   logic [SIDE-1:0] side2_ff;

   // stage 1: four half-width products
   always_ff @(posedge clock) begin
      if (enable) begin
         p00_ff <= in_a[L-1:0] * in_b[L-1:0];
         p01_ff <= in_a[L-1:0] * in_b[W-1:L];
         p10_ff <= in_a[W-1:L] * in_b[L-1:0];
         p11_ff <= in_a[W-1:L] * in_b[W-1:L];
         side_ff <= in_side;
      end
   end

   // stage 2: combine
   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= {{(2*W-2*L){1'b0}}, p00_ff}
                  + ({{(2*W-L-H){1'b0}}, p01_ff} << L)
                  + ({{(2*W-L-H){1'b0}}, p10_ff} << L)
                  + ({{(2*W-2*H){1'b0}}, p11_ff} << (2*L));
         side2_ff <= side_ff;
      end
   end

   assign out_prod = prod_ff;
   assign out_side = side2_ff;
endmodule

[hw/rtl/mma_checker.sv]
// Port-level checker for the Montgomery unit, bound to the top level.
// Depends on montgomery_mod_arith_64_assert.svh.
`include "montgomery_mod_arith_64_assert.svh"
module mma_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [63:0]  rsp_tdata
);
   `MMA_ASSERT_RST(a_rst_quiet, $past(reset) |-> !rsp_tvalid, "valid after reset")
   `MMA_ASSERT(a_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "beat lost")
   `MMA_ASSERT(a_ready, !rsp_tvalid |-> req_tready, "stalled with empty output")
   `MMA_ASSERT(a_top, rsp_tvalid |-> !rsp_tdata[63], "pad bit set")
endmodule

bind montgomery_mod_arith_64 mma_checker u_chk (.*);

[tb/sv/montgomery_mod_arith_64_tb.sv]
// Testbench for montgomery_mod_arith_64: modular add, subtract, Montgomery product
// and domain conversion against an in-bench predictor. Depends on mma_pkg and the RTL.
`timescale 1ns / 1ps

module montgomery_mod_arith_64_tb;
   import mma_pkg::*;

   typedef struct packed {
      logic [62:0] opb;
      logic [63:0] opa;
      logic [2:0]  mode;
   } req_beat_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [135:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = CSR_MODULUS;
   logic [63:0] csr_wdata = '0;

   montgomery_mod_arith_64 i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the registers
   logic [63:0] pred_mod = 64'd1;
   logic [63:0] pred_inv = 64'd1;
   logic [63:0] pred_r2 = 64'd0;

   req_beat_t pending_reqs[$];
   logic [62:0] expected_results[$];
   int errors = 0;
   int sent = 0;
   int received = 0;
   longint cycles = 0;
   bit stim_done = 0;
   bit req_taken = 0;

   function automatic logic [63:0] redc(logic [127:0] x);
      logic [63:0] t;
      logic [127:0] tm;
      logic [63:0] y;
      t = x[63:0] * pred_inv;
      tm = {64'd0, t} * {64'd0, pred_mod};
      y = x[127:64] - tm[127:64];
      if (y[63]) y = y + pred_mod;
      return y;
   endfunction

   function automatic logic [62:0] mod_arith(req_beat_t b);
      logic [63:0] r;
      logic [63:0] bb;
      bb = {1'b0, b.opb};
      case (b.mode)
         MODE_ADD: begin
            r = b.opa + bb - pred_mod;
            if (r[63]) r = r + pred_mod;
         end
         MODE_SUB: begin
            r = b.opa - bb;
            if (r[63]) r = r + pred_mod;
         end
         MODE_MUL: r = redc({64'd0, b.opa} * {64'd0, bb});
         MODE_TO_MONT: r = redc({64'd0, b.opa} * {64'd0, pred_r2});
         MODE_FROM_MONT: r = redc({64'd0, b.opa});
         default: r = '0;
      endcase
      return r[62:0];
   endfunction

   // driver: bursts with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && !req_taken) begin
            // hold the beat
         end else if (pending_reqs.size() > 0 && gap_left == 0) begin
            req_beat_t b;
            b = pending_reqs.pop_front();
            expected_results = {expected_results, mod_arith(b)};
            req_tdata <= {6'd0, b};
            req_tvalid <= 1'b1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
            end else begin
               burst_left--;
               if (burst_left == 0 && $urandom_range(0, 2) != 0)
                  gap_left = $urandom_range(1, 12);
            end
         end else begin
            req_tvalid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end
      end
   end

   // receiver stall pattern: random-length runs, each randomly ready or stalled
   int stall_phase = 0;
   always @(negedge clock) begin
      if (stall_phase == 0) begin
         stall_phase = $urandom_range(1, 30);
         rsp_tready <= ($urandom_range(0, 3) != 0);
      end else begin
         stall_phase--;
      end
   end

   // monitor
   always @(posedge clock) begin
      cycles++;
      req_taken = !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         received++;
         if (expected_results.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            logic [62:0] exp_r;
            exp_r = expected_results.pop_front();
            if (rsp_tdata[62:0] !== exp_r) begin
               $display("%0t: result mismatch expected %h actual %h",
                        $time, exp_r, rsp_tdata[62:0]);
               errors++;
            end
         end
      end
      if (cycles > 400000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic drain();
      wait (pending_reqs.size() == 0 && !req_tvalid);
      wait (expected_results.size() == 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_MODULUS: pred_mod = {1'b0, val[62:0]};
         CSR_INVERSE: pred_inv = val;
         default: pred_r2 = {1'b0, val[62:0]};
      endcase
   endtask

   function automatic logic [63:0] inverse_of(logic [63:0] m);
      logic [63:0] x;
      x = m;
      repeat (6) x = x * (64'd2 - m * x);
      return x;
   endfunction

   // r2 = 2^128 mod m by doubling
   function automatic logic [63:0] r2_of(logic [63:0] m);
      logic [64:0] r;
      r = 65'd1 % m;
      repeat (128) begin
         r = r << 1;
         if (r >= m) r = r - m;
      end
      return r[63:0];
   endfunction

   task automatic set_modulus(logic [63:0] m);
      write_csr(CSR_MODULUS, m);
      write_csr(CSR_INVERSE, inverse_of(m));
      write_csr(CSR_R_SQUARED, r2_of(m));
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [62:0] below(logic [63:0] m);
      logic [63:0] v;
      v = rand64();
      if ($urandom_range(0, 7) == 0) return m[62:0] - 63'd1;
      if ($urandom_range(0, 7) == 0) return '0;
      return 63'(v % m);
   endfunction

   task automatic push(logic [2:0] mode, logic [63:0] a, logic [62:0] b);
      req_beat_t r;
      r.mode = mode;
      r.opa = a;
      r.opb = b;
      pending_reqs = {pending_reqs, r};
      sent++;
   endtask

   task automatic random_phase(int n);
      logic [63:0] m;
      m = pred_mod;
      repeat (n) begin
         int k;
         k = $urandom_range(0, 19);
         if (k == 0) begin
            // noise: any field value, even out of range
            push(3'($urandom_range(0, 7)), rand64(), 63'(rand64()));
         end else if (k == 1) begin
            push(MODE_TO_MONT, rand64(), 63'(rand64()));
         end else begin
            push(3'($urandom_range(0, 4)), {1'b0, below(m)}, below(m));
         end
      end
      drain();
   endtask

   logic [63:0] mods[6];

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed at reset values (modulus one), then at a large odd modulus
      push(MODE_ADD, 64'd0, 63'd0);
      push(MODE_TO_MONT, '1, '1);
      push(3'd7, '1, '1);
      drain();
      set_modulus(64'h7FFF_FFFF_FFFF_FFFF);
      push(MODE_ADD, 64'h7FFF_FFFF_FFFF_FFFE, 63'h7FFF_FFFF_FFFF_FFFE);
      push(MODE_ADD, 64'd0, 63'd0);
      push(MODE_SUB, 64'd0, 63'h7FFF_FFFF_FFFF_FFFE);
      push(MODE_SUB, 64'h7FFF_FFFF_FFFF_FFFE, 63'd0);
      push(MODE_MUL, 64'h7FFF_FFFF_FFFF_FFFE, 63'h7FFF_FFFF_FFFF_FFFE);
      push(MODE_MUL, 64'd1, 63'd1);
      push(MODE_TO_MONT, '1, 63'd5);
      push(MODE_TO_MONT, 64'd0, 63'd0);
      push(MODE_FROM_MONT, 64'h7FFF_FFFF_FFFF_FFFE, '1);
      push(MODE_FROM_MONT, '1, 63'd0);
      push(3'd5, 64'd3, 63'd3);
      push(3'd6, '1, '1);
      drain();
      // wrong inverse and even modulus: datapath runs the same
      write_csr(CSR_INVERSE, '1);
      write_csr(CSR_MODULUS, 64'hFFFF_FFFF_FFFF_FFF0);
      push(MODE_MUL, '1, '1);
      push(MODE_FROM_MONT, 64'h1234_5678_9ABC_DEF0, 63'd0);
      push(MODE_ADD, '1, '1);
      drain();
      write_csr(CSR_R_SQUARED, '1);
      push(MODE_TO_MONT, '1, 63'd0);
      drain();

      mods[0] = 64'd1;
      mods[1] = 64'd3;
      mods[2] = 64'h7FFF_FFFF_FFFF_FFFF;
      mods[3] = 64'h4000_0000_0000_0001;
      mods[4] = {1'b0, 31'($urandom), $urandom} | 64'd1;
      mods[5] = {32'd0, $urandom} | 64'd1;
      foreach (mods[i]) begin
         set_modulus(mods[i]);
         random_phase(180);
      end
      stim_done = 1;

      $display("Covered %0d request beats and %0d results over fixed, random and bad moduli",
               sent, received);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
